// ===== hw/rtl/greedy_graph_coloring_defines.svh =====
// Assertion macros shared by the greedy graph coloring checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GREEDY_GRAPH_COLORING_DEFINES_SVH
`define GREEDY_GRAPH_COLORING_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GGC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggc assertion failed");

`endif

// ===== hw/rtl/ggc_pkg.sv =====
// Shared types and constants of the greedy graph coloring block.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package ggc_pkg;

   localparam int unsigned DEF_MAX_VERTICES = 64;
   localparam int unsigned VERTEX_W         = 6;
   localparam int unsigned COLOR_W          = 6;
   localparam int unsigned COLOR_COUNT      = 64;
   localparam int unsigned CHUNK_W          = 8;

   typedef enum logic [1:0] {
      CMD_CLEAR_ALL    = 2'd0,
      CMD_ADD_EDGE     = 2'd1,
      CMD_CLEAR_COLORS = 2'd2,
      CMD_COLOR_VERTEX = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [VERTEX_W-1:0]   vertex_a;
      logic [VERTEX_W-1:0]   vertex_b;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0]   colored_vertex;
      logic [COLOR_W-1:0]    assigned_color;
   } rsp_type;

endpackage

// ===== hw/rtl/greedy_graph_coloring.sv =====
// Top level of the first-fit greedy graph colorer over an adjacency matrix.
// Depends on ggc_pkg (types, command codes, constants).
//
//   channel   ports                          transfer
//   request   start, busy, req_data          start && !busy at a rising edge
//   response  rsp_valid, rsp_data            one-cycle strobe, always taken
//
// Clear all and clear colors finish in the accept cycle (busy stays low).
// Add edge of two in-range vertices keeps busy high for a read-modify-write of both rows.
// Color vertex of an in-range vertex keeps busy high through one adjacency row
// read, a walk over the color memory one entry a cycle, a drain state, then a
// first-free search over the used-color mask, 8 bits a cycle.
// The response strobe comes in the cycle busy drops; the receiver can't stall.
// Reset is synchronous; it clears the row valid bits and colored flags at once.
`timescale 1ns / 1ps

module greedy_graph_coloring #(
   parameter int unsigned MAX_VERTICES = ggc_pkg::DEF_MAX_VERTICES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ggc_pkg::req_type req_data,
   output logic             rsp_valid,
   output ggc_pkg::rsp_type rsp_data
);

   import ggc_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_VERTICES);
   localparam logic [ADDR_W-1:0] LAST_VTX = ADDR_W'(MAX_VERTICES - 1);
   localparam logic [MAX_VERTICES-1:0] ROW_ONE = MAX_VERTICES'(1);
   localparam logic [COLOR_COUNT-1:0] COLOR_ONE = COLOR_COUNT'(1);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_EDGE_A    = 7'b0000010,
      ST_EDGE_B    = 7'b0000100,
      ST_COL_ROW   = 7'b0001000,
      ST_COL_SCAN  = 7'b0010000,
      ST_COL_DRAIN = 7'b0100000,
      ST_COL_FIND  = 7'b1000000
   } state_type;

   // lowest set bit of an 8-bit chunk; all-zero gives 7
   function automatic logic [2:0] low_one(input logic [CHUNK_W-1:0] v);
      logic [2:0] r;
      r = 3'd7;
      for (int i = CHUNK_W - 1; i >= 0; i--) begin
         if (v[i]) r = 3'(i);
      end
      return r;
   endfunction

   // vertex below MAX_VERTICES
   function automatic logic in_range(input logic [VERTEX_W-1:0] v);
      return {1'b0, v} < (VERTEX_W + 1)'(MAX_VERTICES);
   endfunction

   // ---- storage ----
   logic [MAX_VERTICES-1:0] adj_mem   [MAX_VERTICES];  // adjacency rows
   logic [COLOR_W-1:0]      color_mem [MAX_VERTICES];  // vertex colors

   // ---- registers ----
   state_type               state_ff,     state_in;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;  // row written since clear
   logic [MAX_VERTICES-1:0] flags_ff,     flags_in;      // colored flags
   logic [ADDR_W-1:0]       vtx_a_ff,     vtx_a_in;
   logic [ADDR_W-1:0]       vtx_b_ff,     vtx_b_in;
   logic [MAX_VERTICES-1:0] nbrs_ff,      nbrs_in;       // colored neighbors
   logic [ADDR_W-1:0]       scan_ff,      scan_in;
   logic                    pend_ff,      pend_in;       // color read in flight
   logic                    hit_ff,       hit_in;        // ...and it is a neighbor
   logic [COLOR_COUNT-1:0]  used_ff,      used_in;
   logic [2:0]              chunk_ff,     chunk_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff,  rsp_data_in;

   // memory read data, registered
   logic [MAX_VERTICES-1:0] adj_rd_ff;
   logic                    adj_rd_vld_ff;
   logic [COLOR_W-1:0]      col_rd_ff;

   // ---- memory controls ----
   logic                    adj_rd_en;
   logic [ADDR_W-1:0]       adj_rd_addr;
   logic                    adj_we;
   logic [ADDR_W-1:0]       adj_wr_addr;
   logic [MAX_VERTICES-1:0] adj_wr_data;
   logic                    col_rd_en;
   logic                    col_we;
   logic [COLOR_W-1:0]      col_wr_data;

   logic [MAX_VERTICES-1:0] adj_row;
   logic [CHUNK_W-1:0]      free_bits;
   logic                    accept;
   logic [ADDR_W-1:0]       req_a_idx;
   logic [ADDR_W-1:0]       req_b_idx;

   assign accept    = start && (state_ff == ST_IDLE);
   assign req_a_idx = req_data.vertex_a[ADDR_W-1:0];
   assign req_b_idx = req_data.vertex_b[ADDR_W-1:0];

   // a row never written since the last clear all reads as zero
   assign adj_row   = adj_rd_vld_ff ? adj_rd_ff : '0;
   assign free_bits = ~used_ff[{chunk_ff, 3'b000} +: CHUNK_W];

   always_comb begin
      state_in     = state_ff;
      row_valid_in = row_valid_ff;
      flags_in     = flags_ff;
      vtx_a_in     = vtx_a_ff;
      vtx_b_in     = vtx_b_ff;
      nbrs_in      = nbrs_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      hit_in       = 1'b0;
      used_in      = used_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      adj_rd_en    = 1'b0;
      adj_rd_addr  = vtx_b_ff;
      adj_we       = 1'b0;
      adj_wr_addr  = vtx_a_ff;
      adj_wr_data  = adj_row;
      col_rd_en    = 1'b0;
      col_we       = 1'b0;
      col_wr_data  = {chunk_ff, low_one(free_bits)};

      // fold in the color read issued last cycle
      if (pend_ff && hit_ff) begin
         used_in = used_ff | (COLOR_ONE << col_rd_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            vtx_a_in = req_a_idx;
            vtx_b_in = req_b_idx;
            if (accept) begin
               case (req_data.cmd)
                  CMD_CLEAR_ALL: begin
                     row_valid_in = '0;
                     flags_in     = '0;
                  end
                  CMD_ADD_EDGE: begin
                     if (in_range(req_data.vertex_a) && in_range(req_data.vertex_b)) begin
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = req_a_idx;
                        state_in    = ST_EDGE_A;
                     end
                  end
                  CMD_CLEAR_COLORS: begin
                     flags_in = '0;
                  end
                  default: begin  // color vertex
                     if (in_range(req_data.vertex_a)) begin
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = req_a_idx;
                        state_in    = ST_COL_ROW;
                     end
                  end
               endcase
            end
         end

         ST_EDGE_A: begin
            // write row a; read row b in the same cycle (old data if a == b,
            // which still lands the same bit)
            adj_we                 = 1'b1;
            adj_wr_addr            = vtx_a_ff;
            adj_wr_data            = adj_row | (ROW_ONE << vtx_b_ff);
            row_valid_in[vtx_a_ff] = 1'b1;
            adj_rd_en              = 1'b1;
            adj_rd_addr            = vtx_b_ff;
            state_in               = ST_EDGE_B;
         end

         ST_EDGE_B: begin
            adj_we                 = 1'b1;
            adj_wr_addr            = vtx_b_ff;
            adj_wr_data            = adj_row | (ROW_ONE << vtx_a_ff);
            row_valid_in[vtx_b_ff] = 1'b1;
            state_in               = ST_IDLE;
         end

         ST_COL_ROW: begin
            // own bit ignored; only colored neighbors count
            nbrs_in  = adj_row & flags_ff & ~(ROW_ONE << vtx_a_ff);
            scan_in  = '0;
            used_in  = '0;
            state_in = ST_COL_SCAN;
         end

         ST_COL_SCAN: begin
            col_rd_en = 1'b1;
            pend_in   = 1'b1;
            hit_in    = nbrs_ff[scan_ff];
            if (scan_ff == LAST_VTX) begin
               state_in = ST_COL_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_COL_DRAIN: begin
            chunk_in = '0;
            state_in = ST_COL_FIND;
         end

         ST_COL_FIND: begin
            // top chunk full means color 63, matching the search cap
            if ((free_bits != '0) || (chunk_ff == 3'd7)) begin
               col_we                     = 1'b1;
               flags_in[vtx_a_ff]         = 1'b1;
               rsp_valid_in               = 1'b1;
               rsp_data_in.colored_vertex = VERTEX_W'(vtx_a_ff);
               rsp_data_in.assigned_color = col_wr_data;
               state_in                   = ST_IDLE;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_valid_ff <= '0;
         flags_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         flags_ff     <= flags_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      vtx_a_ff    <= vtx_a_in;
      vtx_b_ff    <= vtx_b_in;
      nbrs_ff     <= nbrs_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      used_ff     <= used_in;
      chunk_ff    <= chunk_in;
      rsp_data_ff <= rsp_data_in;
   end

   // adjacency memory, one read and one write port
   always_ff @(posedge clock) begin
      if (adj_rd_en) begin
         adj_rd_ff     <= adj_mem[adj_rd_addr];
         adj_rd_vld_ff <= row_valid_ff[adj_rd_addr];
      end
      if (adj_we) begin
         adj_mem[adj_wr_addr] <= adj_wr_data;
      end
   end

   // color memory
   always_ff @(posedge clock) begin
      if (col_rd_en) begin
         col_rd_ff <= color_mem[scan_ff];
      end
      if (col_we) begin
         color_mem[vtx_a_ff] <= col_wr_data;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/ggc_checker.sv =====
// Port-level checker for greedy_graph_coloring, with its bind statement.
// Depends on ggc_pkg and greedy_graph_coloring_defines.svh.
`timescale 1ns / 1ps
`include "greedy_graph_coloring_defines.svh"

module ggc_checker #(
   parameter int unsigned MAX_VERTICES = ggc_pkg::DEF_MAX_VERTICES
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input ggc_pkg::req_type req_data,
   input logic             rsp_valid,
   input ggc_pkg::rsp_type rsp_data
);

   import ggc_pkg::*;

   logic take;
   logic color_req;
   logic clear_req;
   logic rsp_in_range;

   assign take      = start && !busy;
   assign color_req = take && (req_data.cmd == CMD_COLOR_VERTEX)
                      && ({1'b0, req_data.vertex_a} < (VERTEX_W + 1)'(MAX_VERTICES));
   assign clear_req = take && ((req_data.cmd == CMD_CLEAR_ALL)
                      || (req_data.cmd == CMD_CLEAR_COLORS));
   assign rsp_in_range =
      ({1'b0, rsp_data.colored_vertex} < (VERTEX_W + 1)'(MAX_VERTICES))
      && ({1'b0, rsp_data.assigned_color} < (COLOR_W + 1)'(MAX_VERTICES));

   // a valid color request occupies the block
   `GGC_ASSERT_NEXT(a_color_busy, clock, reset, color_req, busy)
   // clears finish at once and answer nothing
   `GGC_ASSERT_NEXT(a_clear_quiet, clock, reset, clear_req, !busy && !rsp_valid)
   // a response shows as the block turns ready, never twice in a row
   `GGC_ASSERT_SAME(a_rsp_ready, clock, reset, rsp_valid, !busy)
   `GGC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   // vertex and color both stay below the vertex count
   `GGC_ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)

endmodule

bind greedy_graph_coloring ggc_checker #(
   .MAX_VERTICES(MAX_VERTICES)
) u_ggc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
